FILE: rtl/ght_pkg.sv
package ght_pkg;

  // Field widths of the request, result and configuration port
  localparam int PcW      = 32;
  localparam int AgeW     = 24;
  localparam int CntW     = 7;
  localparam int OpW      = 2;
  localparam int CoreFldW = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 24;

  // Age saturation and register reset values
  localparam logic [AgeW-1:0] AgeMax           = '1;
  localparam logic [AgeW-1:0] GainThresholdRst = 24'd1200;
  localparam logic [CntW-1:0] MaxCountRst      = 7'd127;

  // Request opcodes
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_READ   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_THRESHOLD = 1'b0,
    CFG_MAX_COUNT      = 1'b1
  } cfg_reg_t;

  // Request payload
  typedef struct packed {
    logic [OpW-1:0]      op;
    logic [CoreFldW-1:0] core;
    logic [PcW-1:0]      pc;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic            hit;
    logic [CntW-1:0] ref_count;
    logic            committed;
  } out_res_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [PcW-1:0]  tag;
    logic [CntW-1:0] count;
  } entry_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic write;
    logic respond;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_scan;
    logic commit_q;
    logic match;
    logic exhausted;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/ght_ctrl.sv
module ght_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ght_pkg::dp_status_t status,
  output ght_pkg::ctl_cmd_t   cmd
);

  ght_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ght_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ght_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.start_scan ? ght_pkg::ST_SCAN : ght_pkg::ST_RESP;
        end
      end
      ght_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        // stop at the first matching tag or after the last filled slot
        if (status.match || status.exhausted) begin
          state_nxt = status.commit_q ? ght_pkg::ST_WRITE : ght_pkg::ST_RESP;
        end
      end
      ght_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ght_pkg::ST_RESP;
      end
      ght_pkg::ST_RESP: begin
        if (status.out_free) begin
          cmd.respond = 1'b1;
          state_nxt   = ght_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ght_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ght_dp.sv
module ght_dp #(
  parameter int CORES   = 4,
  parameter int ENTRIES = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ght_pkg::in_req_t                in_data,
  input  logic                            cfg_we,
  input  logic [ght_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [ght_pkg::CfgDataW-1:0]    cfg_wdata,
  input  ght_pkg::ctl_cmd_t               cmd,
  output ght_pkg::dp_status_t             status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ght_pkg::out_res_t               out_data
);

  localparam int CoreW = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int IdxW  = $clog2(ENTRIES);
  localparam int FillW = $clog2(ENTRIES + 1);
  localparam int Depth = CORES * ENTRIES;
  localparam int AddrW = $clog2(Depth);
  localparam int BestW = ght_pkg::CntW + 1;

  localparam logic [FillW-1:0] FillFull = FillW'(ENTRIES);
  localparam logic [BestW-1:0] BestInit = BestW'(1) << ght_pkg::CntW;

  // Configuration
  logic [ght_pkg::AgeW-1:0] gain_threshold_r;
  logic [ght_pkg::CntW-1:0] max_count_r;

  // Per-core last-read registers and table fill counts
  logic                      last_valid_r [CORES];
  logic [ght_pkg::PcW-1:0]   last_pc_r    [CORES];
  logic [ght_pkg::AgeW-1:0]  last_age_r   [CORES];
  logic [FillW-1:0]          fill_r       [CORES];

  // Request in progress
  logic [CoreW-1:0]          core_r;
  logic [ght_pkg::PcW-1:0]   tag_r;
  logic                      commit_r;
  ght_pkg::out_res_t         res_r;

  // Scan
  logic [FillW-1:0]          scan_idx_r;
  logic                      rd_vld_r;
  logic [IdxW-1:0]           rd_idx_r;
  ght_pkg::entry_t           rd_entry_r;
  logic                      found_r;
  logic [IdxW-1:0]           hit_idx_r;
  logic [ght_pkg::CntW-1:0]  hit_cnt_r;
  logic [BestW-1:0]          best_cnt_r;
  logic [IdxW-1:0]           best_idx_r;

  // Output register
  logic                      out_valid_r;
  ght_pkg::out_res_t         out_data_r;

  // Table memory, all cores
  ght_pkg::entry_t           mem [Depth];

  logic [CoreW-1:0]          in_core;
  logic                      core_ok;
  logic                      is_tick;
  logic                      is_read;
  logic                      is_lookup;
  logic                      in_commit;
  logic                      more;
  logic                      issue;
  logic                      match;
  logic [AddrW-1:0]          base;
  logic [AddrW-1:0]          raddr;
  logic [AddrW-1:0]          waddr;
  logic                      has_free;
  logic [IdxW-1:0]           wr_idx;
  logic [BestW-1:0]          inc;
  logic [ght_pkg::CntW-1:0]  wr_cnt;

  // Request decode
  always_comb begin
    in_core   = CoreW'(in_data.core);
    core_ok   = 32'(in_data.core) < CORES;
    is_tick   = in_data.op == ght_pkg::OP_TICK;
    is_read   = (in_data.op == ght_pkg::OP_READ) && core_ok;
    is_lookup = (in_data.op == ght_pkg::OP_LOOKUP) && core_ok;
    in_commit = is_read && last_valid_r[in_core] &&
                (last_age_r[in_core] >= gain_threshold_r);
  end

  // Scan addressing and compare
  always_comb begin
    base     = AddrW'(32'(core_r) * ENTRIES);
    more     = scan_idx_r < fill_r[core_r];
    issue    = cmd.scan && more;
    match    = rd_vld_r && (rd_entry_r.tag == tag_r);
    raddr    = base + AddrW'(scan_idx_r[IdxW-1:0]);
    has_free = fill_r[core_r] < FillFull;
  end

  // Commit slot and count
  always_comb begin
    inc = {1'b0, hit_cnt_r} + BestW'(1);
    if (found_r) begin
      wr_idx = hit_idx_r;
      wr_cnt = (inc >= {1'b0, max_count_r}) ? max_count_r : inc[ght_pkg::CntW-1:0];
    end else begin
      wr_idx = has_free ? fill_r[core_r][IdxW-1:0] : best_idx_r;
      wr_cnt = ght_pkg::CntW'(1);
    end
    waddr = base + AddrW'(wr_idx);
  end

  // Status to controller
  always_comb begin
    status.start_scan = in_commit || is_lookup;
    status.commit_q   = commit_r;
    status.match      = match;
    status.exhausted  = !more && !match;
    status.out_free   = !out_valid_r || !out_stall;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_threshold_r <= ght_pkg::GainThresholdRst;
      max_count_r      <= ght_pkg::MaxCountRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        ght_pkg::CFG_GAIN_THRESHOLD: gain_threshold_r <= cfg_wdata[ght_pkg::AgeW-1:0];
        ght_pkg::CFG_MAX_COUNT:      max_count_r      <= cfg_wdata[ght_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Last-read registers: ageing on tick, restart on read arrival
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORES; i++) begin
        last_valid_r[i] <= 1'b0;
        last_pc_r[i]    <= '0;
        last_age_r[i]   <= '0;
      end
    end else if (cmd.accept) begin
      for (int i = 0; i < CORES; i++) begin
        if (is_tick) begin
          if (last_valid_r[i] && (last_age_r[i] != ght_pkg::AgeMax)) begin
            last_age_r[i] <= last_age_r[i] + ght_pkg::AgeW'(1);
          end
        end else if (is_read && (CoreW'(i) == in_core)) begin
          last_valid_r[i] <= 1'b1;
          last_pc_r[i]    <= in_data.pc;
          last_age_r[i]   <= '0;
        end
      end
    end
  end

  // Fill counts: valid slots always form a prefix of a core's table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CORES; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cmd.write && !found_r && has_free) begin
      fill_r[core_r] <= fill_r[core_r] + FillW'(1);
    end
  end

  // Read pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
    end
  end

  // Request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      core_r     <= in_core;
      commit_r   <= in_commit;
      tag_r      <= in_commit ? last_pc_r[in_core] : in_data.pc;
      res_r      <= '{hit: 1'b0, ref_count: '0, committed: in_commit};
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      best_cnt_r <= BestInit;
      best_idx_r <= '0;
    end else if (cmd.scan) begin
      if (more) begin
        scan_idx_r <= scan_idx_r + FillW'(1);
        rd_idx_r   <= scan_idx_r[IdxW-1:0];
      end
      if (match) begin
        found_r   <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_cnt_r <= rd_entry_r.count;
        if (!commit_r) begin
          res_r.hit       <= 1'b1;
          res_r.ref_count <= rd_entry_r.count;
        end
      end
      // first slot with the lowest count
      if (rd_vld_r && ({1'b0, rd_entry_r.count} < best_cnt_r)) begin
        best_cnt_r <= {1'b0, rd_entry_r.count};
        best_idx_r <= rd_idx_r;
      end
    end
  end

  // Table memory: one read and one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_entry_r <= mem[raddr];
    end
    if (cmd.write) begin
      mem[waddr] <= '{tag: tag_r, count: wr_cnt};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.respond) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/gain_history_table.sv
// Gain history table: per-core tables of read PCs that stayed in a core's
// last-read register for at least gain_threshold ticks. One request is
// handled at a time and gives one result. A tick, a read arrival that
// commits nothing, a request for a core beyond CORES and the unused opcode
// respond without a scan. A lookup scans the filled slots of that core's
// table (at most ENTRIES), and a committing read arrival scans them and
// then writes one slot: the table memory has one read port and the scan
// reads one slot per cycle, stopping early on a tag match. Valid slots
// are tracked by a fill count per core, so no clearing pass runs after
// reset. The next request is taken as soon as the result is in the output
// register, whether or not it has been collected.
module gain_history_table #(
  parameter int CORES   = 4,
  parameter int ENTRIES = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ght_pkg::in_req_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ght_pkg::out_res_t            out_data,
  input  logic                         cfg_we,
  input  logic [ght_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [ght_pkg::CfgDataW-1:0] cfg_wdata
);

  ght_pkg::ctl_cmd_t   cmd;
  ght_pkg::dp_status_t status;

  // Sequencer
  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Registers, table memory and result path
  ght_dp #(
    .CORES   (CORES),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/ght_checker.sv
module ght_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ght_pkg::out_res_t out_data
);

  // One request at a time: stall straight after an accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still in progress");

  // A new result only appears as a request finishes, never while idle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a request in progress");

  // Reset empties the output side and leaves the block ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("bad state after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind gain_history_table ght_checker u_ght_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/gain_history_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the gain history table,
// keeps its own copy of the tables and last-read registers, and compares
// every collected result against the oldest outstanding prediction.
module gain_history_checker #(
  parameter int CORES   = 4,
  parameter int ENTRIES = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  ght_pkg::in_req_t             in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  ght_pkg::out_res_t            out_data,
  input  logic                         cfg_we,
  input  logic [ght_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [ght_pkg::CfgDataW-1:0] cfg_wdata,
  output int                           err_cnt,
  output int                           res_cnt,
  output int                           commit_cnt,
  output int                           hit_cnt
);
  import ght_pkg::*;

  // Predicted per-core tables
  logic            slot_used [CORES][ENTRIES];
  logic [PcW-1:0]  slot_tag  [CORES][ENTRIES];
  logic [CntW-1:0] slot_cnt  [CORES][ENTRIES];

  // Predicted last-read registers and register settings
  logic            rd_valid [CORES];
  logic [PcW-1:0]  rd_pc    [CORES];
  logic [AgeW-1:0] rd_age   [CORES];
  logic [AgeW-1:0] gain_thr;
  logic [CntW-1:0] cnt_cap;

  // Results owed by the block, oldest first
  out_res_t answers_due [$];

  // First valid slot holding this PC, or -1
  function automatic int find_tag(int core, logic [PcW-1:0] pc);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[core][i] && slot_tag[core][i] == pc) return i;
    end
    return -1;
  endfunction

  // First free slot, else the first one with the lowest count
  function automatic int pick_victim(int core);
    int best;
    int lowest;
    best   = 0;
    lowest = 1 << CntW;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!slot_used[core][i]) return i;
      if (int'(slot_cnt[core][i]) < lowest) begin
        lowest = int'(slot_cnt[core][i]);
        best   = i;
      end
    end
    return best;
  endfunction

  // Commit a gainful PC: bump its count on a hit, else claim a slot
  task automatic commit_gain(int core, logic [PcW-1:0] pc);
    int s;
    int n;
    s = find_tag(core, pc);
    if (s >= 0) begin
      n = int'(slot_cnt[core][s]) + 1;
      if (n >= int'(cnt_cap)) n = int'(cnt_cap);
      slot_cnt[core][s] = CntW'(n);
    end else begin
      s = pick_victim(core);
      slot_used[core][s] = 1'b1;
      slot_tag[core][s]  = pc;
      slot_cnt[core][s]  = CntW'(1);
    end
  endtask

  // Apply one request to the predicted state and work out its result
  task automatic table_step(input in_req_t req, output out_res_t res);
    int core;
    int s;
    core = int'(req.core);
    res  = '0;
    case (req.op)
      OP_TICK: begin
        for (int i = 0; i < CORES; i++) begin
          if (rd_valid[i] && rd_age[i] != AgeMax) rd_age[i] = rd_age[i] + 1'b1;
        end
      end
      OP_READ: begin
        if (core < CORES) begin
          if (rd_valid[core] && rd_age[core] >= gain_thr) begin
            commit_gain(core, rd_pc[core]);
            res.committed = 1'b1;
          end
          rd_valid[core] = 1'b1;
          rd_pc[core]    = req.pc;
          rd_age[core]   = '0;
        end
      end
      OP_LOOKUP: begin
        if (core < CORES) begin
          s = find_tag(core, req.pc);
          if (s >= 0) begin
            res.hit       = 1'b1;
            res.ref_count = slot_cnt[core][s];
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sample handshakes at the clock edge: predict on requests, check results
  always @(posedge clk) begin : watch
    out_res_t want;
    if (!rst_n) begin
      for (int c = 0; c < CORES; c++) begin
        for (int i = 0; i < ENTRIES; i++) slot_used[c][i] = 1'b0;
        rd_valid[c] = 1'b0;
        rd_pc[c]    = '0;
        rd_age[c]   = '0;
      end
      gain_thr = GainThresholdRst;
      cnt_cap  = MaxCountRst;
      answers_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_GAIN_THRESHOLD: gain_thr = cfg_wdata[AgeW-1:0];
          CFG_MAX_COUNT:      cnt_cap  = cfg_wdata[CntW-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        table_step(in_data, want);
        answers_due.push_back(want);
        if (want.committed) commit_cnt++;
        if (want.hit) hit_cnt++;
      end

      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, got %0b/%0d/%0b",
                   $time, out_data.hit, out_data.ref_count, out_data.committed);
        end else begin
          want = answers_due.pop_front();
          res_cnt++;
          if (out_data.hit !== want.hit || out_data.ref_count !== want.ref_count ||
              out_data.committed !== want.committed) begin
            err_cnt++;
            $display("%0t: mismatch hit/ref_count/committed: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                     $time, want.hit, want.ref_count, want.committed,
                     out_data.hit, out_data.ref_count, out_data.committed);
          end
        end
      end
    end
  end

endmodule

FILE: tb/gain_history_table_test.sv
`timescale 1ns / 100ps

module gain_history_table_test;
  import ght_pkg::*;

  localparam int CORES      = 4;
  localparam int ENTRIES    = 512;
  localparam int HoldCycles = 600;
  // Slowest request is a committing read on a full table
  localparam int QuietLimit = 20000;
  localparam int FillCount  = 536;

  // Opcode the block must ignore
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_req_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_res_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CFG_GAIN_THRESHOLD;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int err_cnt;
  int res_cnt;
  int commit_cnt;
  int hit_cnt;

  // Requests waiting to be offered, and how many were queued in all
  in_req_t        req_q [$];
  int             issued;
  logic           hold_off = 1'b0;
  logic [PcW-1:0] pc_pool [16];
  logic [PcW-1:0] fill_base;
  int             quiet;
  int             cycles;

  gain_history_table #(
    .CORES   (CORES),
    .ENTRIES (ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  gain_history_checker #(
    .CORES   (CORES),
    .ENTRIES (ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .err_cnt    (err_cnt),
    .res_cnt    (res_cnt),
    .commit_cnt (commit_cnt),
    .hit_cnt    (hit_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic queue_req(logic [OpW-1:0] op, int core, logic [PcW-1:0] pc);
    in_req_t r;
    r.op   = op;
    r.core = CoreFldW'(core);
    r.pc   = pc;
    req_q.push_back(r);
    issued++;
  endtask

  // Block until every queued request has produced its result
  task automatic wait_idle();
    while (res_cnt < issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers; only called while the block is idle
  task automatic set_regs(logic [CfgDataW-1:0] thr, logic [CfgDataW-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GAIN_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx   <= CFG_MAX_COUNT;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Distinct PCs for the table fill: odd multiplier is a bijection
  function automatic logic [PcW-1:0] fill_pc(int i);
    return fill_base ^ (PcW'(i) * 32'h9E37_79B9);
  endfunction

  // Random traffic over a small pool of PCs; ticks let ages reach the threshold
  task automatic add_mix(int n, int core_lo, int core_hi, int pool_n, int tick_pct);
    int             roll;
    int             core;
    logic [PcW-1:0] pc;
    for (int i = 0; i < pool_n; i++) pc_pool[i] = $urandom;
    if ($urandom_range(1, 0) == 1) pc_pool[0] = '0;
    if ($urandom_range(1, 0) == 1) pc_pool[pool_n-1] = '1;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99, 0);
      core = $urandom_range(core_hi, core_lo);
      pc   = ($urandom_range(9, 0) == 0) ? PcW'($urandom) : pc_pool[$urandom_range(pool_n-1, 0)];
      if (roll < tick_pct) queue_req(OP_TICK, core, pc);
      else if (roll < tick_pct + 3) queue_req(OP_UNUSED, core, pc);
      else if ($urandom_range(9, 0) < 6) queue_req(OP_READ, core, pc);
      else queue_req(OP_LOOKUP, core, pc);
    end
  endtask

  // Fill core 3's table past capacity with distinct PCs, revisiting some
  task automatic add_fill();
    int j;
    for (int i = 0; i < FillCount; i++) begin
      queue_req(OP_READ, 3, fill_pc(i));
      if (i % 6 == 5) begin
        // revisit mostly recent PCs so some entries climb while others stay low
        j = ($urandom_range(1, 0) == 1) ? i - $urandom_range(12, 0) : $urandom_range(i, 0);
        case ($urandom_range(3, 0))
          0, 1:    queue_req(OP_READ, 3, fill_pc(j));
          2:       queue_req(OP_LOOKUP, 3, fill_pc(j));
          default: queue_req(OP_TICK, $urandom_range(3, 0), PcW'($urandom));
        endcase
      end
    end
  endtask

  // Request driver: bursts of random length with random gaps
  initial begin : sender
    int burst_left;
    int gap;
    burst_left = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(16, 1);
        gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      if (req_q.size() == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid <= 1'b1;
        in_data  <= req_q[0];
        do @(posedge clk); while (in_stall);
        void'(req_q.pop_front());
        burst_left--;
      end
    end
  end

  // Result side: stall modes in segments, plus one long hold-off on demand
  initial begin : receiver
    int          seg_left;
    int          phase;
    stall_mode_t mode;
    seg_left = 0;
    phase    = 0;
    mode     = STALL_NONE;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_t'($urandom_range(3, 0));
          seg_left = $urandom_range(200, 20);
        end
        seg_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
          default:     out_stall <= ((phase % 7) < 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    cycles++;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, QuietLimit);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fill_base = $urandom;

    // Reset settings: nothing can commit yet, lookups all miss
    queue_req(OP_LOOKUP, 0, '0);
    queue_req(OP_UNUSED, 3, '1);
    queue_req(OP_TICK, 2, '1);
    queue_req(OP_READ, 0, '1);
    queue_req(OP_TICK, 1, '0);
    queue_req(OP_READ, 0, '0);
    queue_req(OP_LOOKUP, 3, '1);
    wait_idle();

    // Commit on every read that follows a read on its core, count saturating at 2
    set_regs('0, 24'd2);
    queue_req(OP_READ, 1, 32'hA5A5_5A5A);
    queue_req(OP_READ, 1, 32'hA5A5_5A5A);
    queue_req(OP_READ, 1, 32'hA5A5_5A5A);
    queue_req(OP_READ, 1, '1);
    queue_req(OP_LOOKUP, 1, 32'hA5A5_5A5A);
    queue_req(OP_READ, 1, '0);
    queue_req(OP_LOOKUP, 1, '1);
    queue_req(OP_LOOKUP, 1, '0);
    queue_req(OP_LOOKUP, 0, '1);
    queue_req(OP_UNUSED, 2, '0);
    wait_idle();

    // Zero count limit, upper data bits set: hits drop counts to 0
    set_regs('0, {17'h1FFFF, 7'h00});
    queue_req(OP_READ, 1, '1);
    queue_req(OP_READ, 1, '0);
    queue_req(OP_LOOKUP, 1, '1);
    queue_req(OP_READ, 1, 32'hA5A5_5A5A);
    queue_req(OP_LOOKUP, 1, '0);
    wait_idle();

    // Largest threshold: reads never commit
    set_regs('1, 24'd127);
    queue_req(OP_TICK, 0, '0);
    queue_req(OP_READ, 2, 32'd5);
    queue_req(OP_READ, 2, 32'd6);
    wait_idle();

    // Random traffic on all cores, with the long receiver hold-off
    set_regs('0, 24'd127);
    add_mix(130, 0, 3, 12, 10);
    hold_off = 1'b1;
    wait_idle();

    // Small threshold: ticks decide which reads commit
    set_regs(24'd2, 24'd3);
    add_mix(130, 0, 3, 8, 45);
    wait_idle();

    // Build high counts on core 2
    set_regs('0, 24'd127);
    add_mix(60, 2, 2, 3, 0);
    wait_idle();

    // Lower the limit below existing counts
    set_regs(24'd1, 24'd1);
    add_mix(70, 0, 2, 6, 35);
    wait_idle();

    // Fill core 3 and force lowest-count replacement
    set_regs('0, 24'd4);
    add_fill();
    wait_idle();

    // Zero limit over a full table
    set_regs('0, '0);
    add_mix(70, 0, 3, 6, 10);
    wait_idle();

    // Largest threshold again, lookups over the filled table
    set_regs('1, 24'd127);
    add_mix(30, 0, 3, 8, 30);
    for (int i = 0; i < 30; i++) begin
      queue_req(OP_LOOKUP, 3, fill_pc($urandom_range(FillCount-1, 0)));
    end
    wait_idle();

    repeat (20) @(posedge clk);
    $display("%0d requests, %0d cycles: %0d results checked, %0d commits, %0d lookup hits",
             issued, cycles, res_cnt, commit_cnt, hit_cnt);
    $display("Thresholds 0 to max, count limits 0 to 127, one table filled past capacity");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
